/* rtl/core/rlk_pkg.sv */
// ----------------------------------------------------------------------------
// rlk_pkg
// Shared types and constants of the radius limited knn search block:
// transfer payloads, register indexes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package rlk_pkg;

  // fixed field widths of the ports
  localparam int IDX_FIELD_W   = 10;
  localparam int COORD_FIELD_W = 16;
  localparam int DIST_W        = 34;
  localparam int RANK_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int WANTED_W      = 5;
  localparam int POINTS_W      = 11;
  localparam int CFG_DATA_W    = 34;
  localparam int CFG_IDX_W     = 2;

  // register reset values
  localparam logic [DIST_W-1:0]   RADIUS_RST = '0;
  localparam logic [WANTED_W-1:0] WANTED_RST = 5'd8;
  localparam logic [POINTS_W-1:0] POINTS_RST = 11'd1024;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WANTED = 2'd1,
    CFG_POINTS = 2'd2
  } cfg_idx_t;

  // query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_QCAP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // input transfer payload
  typedef struct packed {
    logic                     req_type;
    logic [IDX_FIELD_W-1:0]   point_index;
    logic [COORD_FIELD_W-1:0] coord_x;
    logic [COORD_FIELD_W-1:0] coord_y;
    logic [COORD_FIELD_W-1:0] coord_z;
  } rlk_in_t;

  // result transfer payload
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] neighbour_index;
    logic [DIST_W-1:0]      distance_squared;
    logic [RANK_W-1:0]      rank;
    logic [COUNT_W-1:0]     neighbour_count;
    logic                   found;
    logic                   last;
  } rlk_out_t;

  // control broadcast to every cell of the sorted chain
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } rlk_cell_ctrl_t;

endpackage

/* rtl/core/rlk_ram.sv */
// ----------------------------------------------------------------------------
// rlk_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rlk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rlk_dist.sv */
// ----------------------------------------------------------------------------
// rlk_dist
// Three stage squared distance pipeline: absolute differences, squares,
// then sum and inclusive radius check producing an insert candidate.
// ----------------------------------------------------------------------------
module rlk_dist #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [IDX_W-1:0]               in_idx,
  input  logic [3*COORD_BITS-1:0]        in_point,
  input  logic [3*COORD_BITS-1:0]        q_point,
  input  logic [rlk_pkg::DIST_W-1:0]     radius,
  output logic                           cand_vld,
  output logic [IDX_W-1:0]               cand_idx,
  output logic [rlk_pkg::DIST_W-1:0]     cand_dist,
  output logic                           pending
);

  import rlk_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  logic [COORD_BITS-1:0] d_nxt   [3];
  logic [COORD_BITS-1:0] d_r     [3];
  logic [SQ_W-1:0]       sq_nxt  [3];
  logic [SQ_W-1:0]       sq_r    [3];
  logic                  s1_vld_r;
  logic                  s2_vld_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [IDX_W-1:0]      s2_idx_r;
  logic [SUM_W-1:0]      sum;
  logic                  in_range;
  logic                  cand_vld_r;
  logic [IDX_W-1:0]      cand_idx_r;
  logic [DIST_W-1:0]     cand_dist_r;

  // per axis absolute difference
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (q_point[l*COORD_BITS +: COORD_BITS] >= in_point[l*COORD_BITS +: COORD_BITS]) begin
        d_nxt[l] = q_point[l*COORD_BITS +: COORD_BITS] - in_point[l*COORD_BITS +: COORD_BITS];
      end else begin
        d_nxt[l] = in_point[l*COORD_BITS +: COORD_BITS] - q_point[l*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // per axis square
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_nxt[l] = SQ_W'(d_r[l]) * SQ_W'(d_r[l]);
    end
  end

  // sum of squares and inclusive radius bound
  assign sum      = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  assign in_range = CMP_W'(sum) <= CMP_W'(radius);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
    end else begin
      s1_vld_r   <= in_vld;
      s2_vld_r   <= s1_vld_r;
      cand_vld_r <= s2_vld_r && in_range;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    s1_idx_r    <= in_idx;
    s2_idx_r    <= s1_idx_r;
    cand_idx_r  <= s2_idx_r;
    cand_dist_r <= DIST_W'(sum);
  end

  assign cand_vld  = cand_vld_r;
  assign cand_idx  = cand_idx_r;
  assign cand_dist = cand_dist_r;
  assign pending   = s1_vld_r || s2_vld_r || cand_vld_r;

endmodule

/* rtl/core/rlk_cell.sv */
// ----------------------------------------------------------------------------
// rlk_cell
// One slot of the sorted neighbour chain. On insert a cell keeps its entry,
// takes the entry of its left neighbor or takes the candidate; on shift it
// takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module rlk_cell #(
  parameter int IDX_W = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rlk_pkg::rlk_cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]               cand_idx,
  input  logic [rlk_pkg::DIST_W-1:0]     cand_dist,
  input  logic                           left_take,
  input  logic                           left_vld,
  input  logic [IDX_W-1:0]               left_idx,
  input  logic [rlk_pkg::DIST_W-1:0]     left_dist,
  input  logic                           right_vld,
  input  logic [IDX_W-1:0]               right_idx,
  input  logic [rlk_pkg::DIST_W-1:0]     right_dist,
  output logic                           vld,
  output logic [IDX_W-1:0]               idx,
  output logic [rlk_pkg::DIST_W-1:0]     sq_dist,
  output logic                           take
);

  import rlk_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] dist_nxt;

  // strictly greater so that an earlier equal distance stays in front
  assign take = ctrl.insert && (!vld_r || (dist_r > cand_dist));

  // slot update
  always_comb begin
    vld_nxt  = vld_r;
    idx_nxt  = idx_r;
    dist_nxt = dist_r;
    if (ctrl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctrl.shift) begin
      vld_nxt  = right_vld;
      idx_nxt  = right_idx;
      dist_nxt = right_dist;
    end else if (take) begin
      if (left_take) begin
        vld_nxt  = left_vld;
        idx_nxt  = left_idx;
        dist_nxt = left_dist;
      end else begin
        vld_nxt  = 1'b1;
        idx_nxt  = cand_idx;
        dist_nxt = cand_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    dist_r <= dist_nxt;
  end

  assign vld     = vld_r;
  assign idx     = idx_r;
  assign sq_dist = dist_r;

endmodule

/* rtl/core/radius_limited_knn_search.sv */
// ----------------------------------------------------------------------------
// radius_limited_knn_search
// Fixed radius k nearest neighbour search over a store of 3-D points.
// ----------------------------------------------------------------------------
// A load (req_type 0) writes one point into the store; busy stays low. A
// query (req_type 1) raises busy and scans store entries 0 .. points_in_use-1,
// one point a cycle through the single read port of the point store. Matches
// enter a chain of MAX_NEIGHBOURS sorted cells. Results appear one per cycle
// on out_data with out_valid high for exactly one cycle; they cannot be
// stalled. The last result of a query has last set, and busy falls in the
// cycle that result is shown. Store entries read before they are written
// return undefined data; there is no clearing pass after reset.
// Configuration must be written only while busy is low; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module radius_limited_knn_search #(
  parameter int MAX_POINTS     = 1024,
  parameter int MAX_NEIGHBOURS = 16,
  parameter int COORD_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            start,
  output logic                            busy,
  input  rlk_pkg::rlk_in_t                in_data,
  // result channel
  output logic                            out_valid,
  output rlk_pkg::rlk_out_t               out_data,
  // configuration port
  input  logic                            cfg_we,
  input  logic [rlk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import rlk_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int SW = $clog2(MAX_POINTS + 1);
  localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int PW = 3 * COORD_BITS;

  // configuration registers
  logic [DIST_W-1:0]   cfg_radius_r;
  logic [WANTED_W-1:0] cfg_wanted_r;
  logic [POINTS_W-1:0] cfg_points_r;

  // sequencer
  state_t           state_r;
  state_t           state_nxt;
  logic [AW-1:0]    qidx_r;
  logic [CW-1:0]    limit_r;
  logic [SW-1:0]    scan_r;
  logic [SW-1:0]    j_r;
  logic [CW-1:0]    k_r;
  logic [CW-1:0]    n_r;
  logic [CW-1:0]    cnt_r;
  logic [PW-1:0]    q_r;

  // read token aligned with the store read data
  logic             p0_vld_r;
  logic [AW-1:0]    p0_idx_r;

  // accept side decode
  logic             load_acc;
  logic             query_acc;
  logic             q_ok;
  logic [CW-1:0]    limit_in;
  logic [SW-1:0]    scan_in;
  logic             empty_in;

  // sequencer outputs
  logic             issue;
  logic             emit;
  logic             scan_done;
  logic             emit_done;
  logic [AW-1:0]    rd_addr;
  rlk_cell_ctrl_t   ctrl;

  // store and distance pipe
  logic [PW-1:0]    st_wdata;
  logic [PW-1:0]    st_rdata;
  logic             cand_vld;
  logic [AW-1:0]    cand_idx;
  logic [DIST_W-1:0] cand_dist;
  logic             dist_pending;

  // cell chain
  logic [MAX_NEIGHBOURS-1:0] c_vld;
  logic [AW-1:0]             c_idx  [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]         c_dist [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS:0]   c_take;

  // result register
  logic             out_valid_r;
  rlk_out_t         out_data_r;
  rlk_out_t         out_data_nxt;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= RADIUS_RST;
      cfg_wanted_r <= WANTED_RST;
      cfg_points_r <= POINTS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: cfg_radius_r <= cfg_wdata[DIST_W-1:0];
        CFG_WANTED: cfg_wanted_r <= cfg_wdata[WANTED_W-1:0];
        CFG_POINTS: cfg_points_r <= cfg_wdata[POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input transfer decode
  assign busy      = (state_r != ST_IDLE);
  assign load_acc  = start && !busy && (in_data.req_type == REQ_LOAD);
  assign query_acc = start && !busy && (in_data.req_type == REQ_QUERY);
  assign q_ok      = 32'(in_data.point_index) < MAX_POINTS;

  // saturate the register values to the chain and store sizes
  assign limit_in = (32'(cfg_wanted_r) > MAX_NEIGHBOURS) ? CW'(MAX_NEIGHBOURS)
                                                         : CW'(cfg_wanted_r);
  assign scan_in  = (32'(cfg_points_r) > MAX_POINTS) ? SW'(MAX_POINTS)
                                                     : SW'(cfg_points_r);
  assign empty_in = !q_ok || (limit_in == '0) || (scan_in == '0);

  assign scan_done = (j_r == (scan_r - SW'(1)));
  assign emit_done = (n_r == '0) || (k_r == (n_r - CW'(1)));

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = empty_in ? ST_EMIT : ST_QREAD;
        end
      end
      ST_QREAD: state_nxt = ST_QCAP;
      ST_QCAP:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p0_vld_r && !dist_pending) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue       = 1'b0;
    emit        = 1'b0;
    rd_addr     = j_r[AW-1:0];
    ctrl.clear  = 1'b0;
    ctrl.insert = cand_vld;
    ctrl.shift  = 1'b0;
    case (state_r)
      ST_IDLE:  ctrl.clear = query_acc;
      ST_QREAD: rd_addr = qidx_r;
      ST_QCAP:  ;
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: ;
      ST_EMIT: begin
        emit       = 1'b1;
        ctrl.shift = (n_r != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // query bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
      k_r   <= '0;
      j_r   <= '0;
    end else begin
      if (query_acc) begin
        cnt_r <= '0;
      end else if (ctrl.shift) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (ctrl.insert && c_take[MAX_NEIGHBOURS] &&
                   (32'(cnt_r) != MAX_NEIGHBOURS)) begin
        cnt_r <= cnt_r + CW'(1);
      end

      if (query_acc) begin
        n_r <= '0;
      end else if (state_r == ST_DRAIN) begin
        n_r <= (cnt_r < limit_r) ? cnt_r : limit_r;
      end

      if (query_acc) begin
        k_r <= '0;
      end else if (emit) begin
        k_r <= k_r + CW'(1);
      end

      if (query_acc) begin
        j_r <= '0;
      end else if (issue) begin
        j_r <= j_r + SW'(1);
      end
    end
  end

  // query operands
  always_ff @(posedge clk) begin
    if (query_acc) begin
      qidx_r  <= AW'(in_data.point_index);
      limit_r <= limit_in;
      scan_r  <= scan_in;
    end
    if (state_r == ST_QCAP) begin
      q_r <= st_rdata;
    end
  end

  // read token, the queried point itself is dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= issue && (j_r[AW-1:0] != qidx_r);
    end
  end

  always_ff @(posedge clk) begin
    p0_idx_r <= j_r[AW-1:0];
  end

  // ---------------------------------------------------------------------------
  // point store
  assign st_wdata = {COORD_BITS'(in_data.coord_x),
                     COORD_BITS'(in_data.coord_y),
                     COORD_BITS'(in_data.coord_z)};

  rlk_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (load_acc && q_ok),
    .waddr (AW'(in_data.point_index)),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  // distance pipeline
  rlk_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (AW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (p0_vld_r),
    .in_idx    (p0_idx_r),
    .in_point  (st_rdata),
    .q_point   (q_r),
    .radius    (cfg_radius_r),
    .cand_vld  (cand_vld),
    .cand_idx  (cand_idx),
    .cand_dist (cand_dist),
    .pending   (dist_pending)
  );

  // ---------------------------------------------------------------------------
  // sorted cell chain, cell 0 holds the nearest entry
  assign c_take[0] = 1'b0;

  for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
    logic              l_vld;
    logic [AW-1:0]     l_idx;
    logic [DIST_W-1:0] l_dist;
    logic              r_vld;
    logic [AW-1:0]     r_idx;
    logic [DIST_W-1:0] r_dist;

    if (i == 0) begin : g_head
      assign l_vld  = 1'b0;
      assign l_idx  = '0;
      assign l_dist = '0;
    end else begin : g_body
      assign l_vld  = c_vld[i-1];
      assign l_idx  = c_idx[i-1];
      assign l_dist = c_dist[i-1];
    end

    if (i == MAX_NEIGHBOURS - 1) begin : g_tail
      assign r_vld  = 1'b0;
      assign r_idx  = '0;
      assign r_dist = '0;
    end else begin : g_mid
      assign r_vld  = c_vld[i+1];
      assign r_idx  = c_idx[i+1];
      assign r_dist = c_dist[i+1];
    end

    rlk_cell #(
      .IDX_W (AW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cand_idx   (cand_idx),
      .cand_dist  (cand_dist),
      .left_take  (c_take[i]),
      .left_vld   (l_vld),
      .left_idx   (l_idx),
      .left_dist  (l_dist),
      .right_vld  (r_vld),
      .right_idx  (r_idx),
      .right_dist (r_dist),
      .vld        (c_vld[i]),
      .idx        (c_idx[i]),
      .sq_dist    (c_dist[i]),
      .take       (c_take[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // result formatting, head of the chain or the empty answer
  always_comb begin
    out_data_nxt = '0;
    if (n_r == '0) begin
      out_data_nxt.last = 1'b1;
    end else begin
      out_data_nxt.neighbour_index  = IDX_FIELD_W'(c_idx[0]);
      out_data_nxt.distance_squared = c_dist[0];
      out_data_nxt.rank             = RANK_W'(k_r);
      out_data_nxt.neighbour_count  = COUNT_W'(n_r);
      out_data_nxt.found            = 1'b1;
      out_data_nxt.last             = (k_r == (n_r - CW'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions

  // the end of a query shows its final result
  a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_data.last))
    else $error("query ended without a final result transfer");

  // an empty answer is always the only result
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> out_data.last)
    else $error("empty answer not marked last");

  // valid cells form an unbroken run from the head
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld & (c_vld + MAX_NEIGHBOURS'(1))) == '0)
    else $error("gap in the cell chain");

  // the fill count tracks the valid cells
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_vld) == 32'(cnt_r))
    else $error("fill count differs from valid cells");

  // results come only from the emit phase
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("result transfer outside emit phase");

endmodule

/* tb/radius_limited_knn_search_test.sv */
// ----------------------------------------------------------------------------
// radius_limited_knn_search_test
// Self-checking bench for the fixed radius k nearest neighbour search. A short
// table of directed loads, queries and register writes hits the corner cases.
// Random phases then load clustered point clouds and query them under varied
// radius, neighbour limit and store size. Every result is checked against a
// neighbour predictor kept in the bench or against an answer from the table.
// ----------------------------------------------------------------------------
module radius_limited_knn_search_test;
  import rlk_pkg::*;

  localparam int NUM_POINTS   = 1024;
  localparam int NUM_NB       = 16;
  localparam int MAX_CYCLES   = 600000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 115;
  localparam int DRAIN_CYCLES = 40;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [DIST_W-1:0] RADIUS_MAX = '1;
  // squared distance between opposite corners of the coordinate cube
  localparam logic [DIST_W-1:0] FAR_DIST = 34'd12884508675;
  localparam rlk_out_t EMPTY_ANSWER = '{neighbour_index: '0, distance_squared: '0,
                                        rank: '0, neighbour_count: '0,
                                        found: 1'b0, last: 1'b1};

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    rlk_in_t               item;
    logic                  typed;
    rlk_out_t              want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  rlk_in_t               in_data;
  logic                  out_valid;
  rlk_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor copy of the store and the registers
  logic [COORD_FIELD_W-1:0] pt_x [NUM_POINTS];
  logic [COORD_FIELD_W-1:0] pt_y [NUM_POINTS];
  logic [COORD_FIELD_W-1:0] pt_z [NUM_POINTS];
  logic [DIST_W-1:0]        cur_radius;
  logic [WANTED_W-1:0]      cur_wanted;
  logic [POINTS_W-1:0]      cur_points;
  rlk_out_t                 pending_results [$];
  rlk_out_t                 exp_head;

  // stimulus bookkeeping
  dir_row_t dir_rows [$];
  bit       written [NUM_POINTS];
  int       written_list [$];
  logic     in_taken = 1'b0;
  logic     typed_use;
  rlk_out_t typed_want;
  bit       gaps_on;
  int       burst_left;
  int       rnd_items;
  int       err_count = 0;
  int       cycle_count = 0;
  int       ph_spread;
  int       ph_cx;
  int       ph_cy;
  int       ph_cz;

  radius_limited_knn_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // squared difference of one coordinate
  function automatic longint unsigned sq_gap(input logic [COORD_FIELD_W-1:0] a,
                                             input logic [COORD_FIELD_W-1:0] b);
    longint unsigned d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // append one predicted result
  function automatic void queue_result(input rlk_out_t r);
    pending_results = {pending_results, r};
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // scan the store around one point and queue the neighbours it should report
  task automatic predict_neighbours(input logic [IDX_FIELD_W-1:0] qi);
    logic [IDX_FIELD_W-1:0] nb_idx [NUM_NB];
    logic [DIST_W-1:0]      nb_dist [NUM_NB];
    longint unsigned        d;
    int                     cnt;
    int                     lim;
    int                     scan;
    int                     pos;
    int                     e;
    rlk_out_t               r;
    cnt  = 0;
    scan = (cur_points > NUM_POINTS) ? NUM_POINTS : int'(cur_points);
    lim  = (cur_wanted > NUM_NB) ? NUM_NB : int'(cur_wanted);
    if (lim > 0) begin
      for (int j = 0; j < scan; j++) begin
        if (j != int'(qi)) begin
          d = sq_gap(pt_x[qi], pt_x[j]) + sq_gap(pt_y[qi], pt_y[j]) +
              sq_gap(pt_z[qi], pt_z[j]);
          if (d <= 64'(cur_radius)) begin
            // goes behind every kept entry of equal or smaller distance
            pos = 0;
            while (pos < cnt && 64'(nb_dist[pos]) <= d) pos++;
            if (pos < lim) begin
              e = (cnt < lim) ? cnt : lim - 1;
              while (e > pos) begin
                nb_idx[e]  = nb_idx[e-1];
                nb_dist[e] = nb_dist[e-1];
                e--;
              end
              nb_idx[pos]  = IDX_FIELD_W'(j);
              nb_dist[pos] = DIST_W'(d);
              if (cnt < lim) cnt++;
            end
          end
        end
      end
    end
    if (cnt == 0) begin
      queue_result(EMPTY_ANSWER);
    end else begin
      for (int k = 0; k < cnt; k++) begin
        r.neighbour_index  = nb_idx[k];
        r.distance_squared = nb_dist[k];
        r.rank             = RANK_W'(k);
        r.neighbour_count  = COUNT_W'(cnt);
        r.found            = 1'b1;
        r.last             = (k == cnt - 1);
        queue_result(r);
      end
    end
  endtask

  // result check, store update and prediction on each input transfer
  always @(posedge clk) begin
    in_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected result: idx %0d dist %0d rank %0d count %0d found %0b last %0b",
                   out_data.neighbour_index, out_data.distance_squared, out_data.rank,
                   out_data.neighbour_count, out_data.found, out_data.last);
      end else begin
        exp_head = pending_results.pop_front();
        if (out_data !== exp_head) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("mismatch: expected idx %0d dist %0d rank %0d count %0d found %0b last %0b",
                     exp_head.neighbour_index, exp_head.distance_squared, exp_head.rank,
                     exp_head.neighbour_count, exp_head.found, exp_head.last);
            $display("          actual   idx %0d dist %0d rank %0d count %0d found %0b last %0b",
                     out_data.neighbour_index, out_data.distance_squared, out_data.rank,
                     out_data.neighbour_count, out_data.found, out_data.last);
          end
        end
      end
    end
    if (rst_n && start && !busy) begin
      if (in_data.req_type == REQ_LOAD) begin
        pt_x[in_data.point_index] = in_data.coord_x;
        pt_y[in_data.point_index] = in_data.coord_y;
        pt_z[in_data.point_index] = in_data.coord_z;
      end else if (typed_use) begin
        queue_result(typed_want);
      end else begin
        predict_neighbours(in_data.point_index);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic rlk_in_t mk_item(input logic rq, input int idx,
                                      input logic [COORD_FIELD_W-1:0] x,
                                      input logic [COORD_FIELD_W-1:0] y,
                                      input logic [COORD_FIELD_W-1:0] z);
    rlk_in_t it;
    it.req_type    = rq;
    it.point_index = IDX_FIELD_W'(idx);
    it.coord_x     = x;
    it.coord_y     = y;
    it.coord_z     = z;
    return it;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t load_row(input int idx, input logic [COORD_FIELD_W-1:0] x,
                                        input logic [COORD_FIELD_W-1:0] y,
                                        input logic [COORD_FIELD_W-1:0] z);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_LOAD;
    r.item = mk_item(REQ_LOAD, idx, x, y, z);
    return r;
  endfunction

  function automatic dir_row_t query_row(input int idx, input logic typed,
                                         input rlk_out_t want);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_QUERY;
    r.item  = mk_item(REQ_QUERY, idx, '0, '0, '0);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // answer holding exactly one neighbour
  function automatic rlk_out_t one_hit(input int idx, input logic [DIST_W-1:0] d2);
    rlk_out_t r;
    r.neighbour_index  = IDX_FIELD_W'(idx);
    r.distance_squared = d2;
    r.rank             = '0;
    r.neighbour_count  = COUNT_W'(1);
    r.found            = 1'b1;
    r.last             = 1'b1;
    return r;
  endfunction

  // random point: mostly around the phase cluster, some copies, some anywhere
  function automatic rlk_in_t gen_load(input int idx);
    int      j;
    rlk_in_t it;
    it = mk_item(REQ_LOAD, idx, '0, '0, '0);
    case ($urandom_range(0, 9))
      0: begin
        it.coord_x = COORD_FIELD_W'($urandom);
        it.coord_y = COORD_FIELD_W'($urandom);
        it.coord_z = COORD_FIELD_W'($urandom);
      end
      1: begin
        j = written_list[$urandom_range(0, written_list.size() - 1)];
        it.coord_x = pt_x[j];
        it.coord_y = pt_y[j];
        it.coord_z = pt_z[j];
      end
      default: begin
        it.coord_x = COORD_FIELD_W'(ph_cx + int'($urandom_range(0, ph_spread)));
        it.coord_y = COORD_FIELD_W'(ph_cy + int'($urandom_range(0, ph_spread)));
        it.coord_z = COORD_FIELD_W'(ph_cz + int'($urandom_range(0, ph_spread)));
      end
    endcase
    return it;
  endfunction

  // present one item and hold it until the transfer, then maybe pause
  task automatic drive_item(input rlk_in_t it, input logic typed, input rlk_out_t want);
    typed_use  = typed;
    typed_want = want;
    in_data <= it;
    start   <= 1'b1;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    if (it.req_type == REQ_LOAD && !written[it.point_index]) begin
      written[it.point_index] = 1'b1;
      written_list = {written_list, int'(it.point_index)};
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop start and wait until every result is in and the block is quiet
  task automatic wait_idle();
    start <= 1'b0;
    while (busy || pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_RADIUS: cur_radius = val;
      CFG_WANTED: cur_wanted = val[WANTED_W-1:0];
      CFG_POINTS: cur_points = val[POINTS_W-1:0];
      default: ;
    endcase
  endtask

  // one random setting: fill the scanned range, then mixed loads and queries
  task automatic run_phase(input int n_cfg, input int n_mixed);
    int                    eff;
    int                    qi;
    logic [CFG_DATA_W-1:0] rad;
    logic [CFG_DATA_W-1:0] wanted;
    wait_idle();
    gaps_on    = ($urandom_range(0, 3) != 0);
    burst_left = $urandom_range(1, 10);
    case ($urandom_range(0, 4))
      0: ph_spread = 3;
      1: ph_spread = 40;
      2: ph_spread = 700;
      3: ph_spread = 12000;
      default: ph_spread = 65535;
    endcase
    ph_cx = $urandom_range(0, 65535 - ph_spread);
    ph_cy = $urandom_range(0, 65535 - ph_spread);
    ph_cz = $urandom_range(0, 65535 - ph_spread);
    case ($urandom_range(0, 5))
      0: rad = '0;
      1: rad = RADIUS_MAX;
      2: rad = {2'($urandom_range(0, 3)), 32'($urandom)};
      default: rad = CFG_DATA_W'((64'($urandom_range(0, 65535)) *
                                  64'(3 * longint'(ph_spread) * ph_spread)) >> 16);
    endcase
    case ($urandom_range(0, 4))
      0: wanted = CFG_DATA_W'($urandom_range(17, 31));
      1: wanted = CFG_DATA_W'(1);
      2: wanted = CFG_DATA_W'(NUM_NB);
      default: wanted = CFG_DATA_W'($urandom_range(1, NUM_NB));
    endcase
    write_reg(CFG_POINTS, CFG_DATA_W'(n_cfg));
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_WANTED, wanted);
    eff = (n_cfg > NUM_POINTS) ? NUM_POINTS : n_cfg;
    for (int k = 0; k < eff; k++) begin
      drive_item(gen_load(k), 1'b0, EMPTY_ANSWER);
      rnd_items++;
    end
    for (int k = 0; k < n_mixed; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        // mostly points inside the scanned range, some picked from all written points
        if ($urandom_range(0, 9) < 7)
          qi = int'($urandom_range(0, eff - 1));
        else
          qi = written_list[$urandom_range(0, written_list.size() - 1)];
        drive_item(mk_item(REQ_QUERY, qi, COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom),
                           COORD_FIELD_W'($urandom)), 1'b0, EMPTY_ANSWER);
      end else begin
        qi = $urandom_range(0, 1) ? int'($urandom_range(0, eff - 1))
                                  : int'($urandom_range(0, NUM_POINTS - 1));
        drive_item(gen_load(qi), 1'b0, EMPTY_ANSWER);
      end
      rnd_items++;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    typed_use  = 1'b0;
    typed_want = EMPTY_ANSWER;
    gaps_on    = 1'b1;
    burst_left = 2;
    rnd_items  = 0;
    cur_radius = RADIUS_RST;
    cur_wanted = WANTED_RST;
    cur_points = POINTS_RST;

    // directed table: opposite corners first, radius still at reset
    add_row(cfg_row(CFG_POINTS, 34'd2));
    add_row(load_row(0, 16'h0000, 16'h0000, 16'h0000));
    add_row(load_row(1, 16'hffff, 16'hffff, 16'hffff));
    add_row(query_row(0, 1'b1, EMPTY_ANSWER));
    add_row(cfg_row(CFG_RADIUS, RADIUS_MAX));
    add_row(cfg_row(CFG_WANTED, CFG_DATA_W'(NUM_NB)));
    add_row(query_row(0, 1'b1, one_hit(1, FAR_DIST)));
    add_row(query_row(1, 1'b1, one_hit(0, FAR_DIST)));
    // equal distances: lower index has to come first
    add_row(load_row(2, 16'h0000, 16'h0000, 16'h0000));
    add_row(load_row(3, 16'h0000, 16'h0000, 16'h0000));
    add_row(load_row(4, 16'h0001, 16'h0000, 16'h0000));
    add_row(cfg_row(CFG_POINTS, 34'd5));
    add_row(query_row(2, 1'b0, EMPTY_ANSWER));
    // neighbour limit above the chain length saturates
    add_row(cfg_row(CFG_WANTED, 34'd31));
    add_row(query_row(4, 1'b0, EMPTY_ANSWER));
    add_row(cfg_row(CFG_WANTED, 34'd1));
    add_row(query_row(3, 1'b0, EMPTY_ANSWER));
    // zero neighbours wanted gives the empty answer
    add_row(cfg_row(CFG_WANTED, 34'd0));
    add_row(query_row(0, 1'b1, EMPTY_ANSWER));
    // radius bound is inclusive
    add_row(cfg_row(CFG_WANTED, CFG_DATA_W'(NUM_NB)));
    add_row(cfg_row(CFG_RADIUS, 34'd1));
    add_row(query_row(4, 1'b0, EMPTY_ANSWER));
    // nothing scanned, and only the queried point itself scanned
    add_row(cfg_row(CFG_POINTS, 34'd0));
    add_row(query_row(0, 1'b1, EMPTY_ANSWER));
    add_row(cfg_row(CFG_POINTS, 34'd1));
    add_row(query_row(0, 1'b1, EMPTY_ANSWER));
    // query point beyond the scanned range
    add_row(query_row(2, 1'b0, EMPTY_ANSWER));
    // write to the unmapped index must change nothing
    add_row(cfg_row(CFG_SPARE, '1));
    add_row(query_row(2, 1'b0, EMPTY_ANSWER));
    add_row(load_row(5, 16'haaaa, 16'h5555, 16'haaaa));
    add_row(load_row(6, 16'h5555, 16'haaaa, 16'h5555));
    add_row(load_row(1023, 16'hffff, 16'h0000, 16'hffff));
    add_row(cfg_row(CFG_POINTS, 34'd7));
    add_row(cfg_row(CFG_RADIUS, RADIUS_MAX));
    add_row(query_row(5, 1'b0, EMPTY_ANSWER));
    add_row(query_row(6, 1'b0, EMPTY_ANSWER));
    add_row(query_row(1023, 1'b0, EMPTY_ANSWER));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases over small stores
    while (rnd_items < RANDOM_ITEMS) begin
      run_phase(($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 48)),
                int'($urandom_range(14, 24)));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
